[rtl/core/sparse_csc_vertex_isolation_core_macros.svh]
// Assertion macros for the sparse CSC vertex isolation core.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef SPARSE_CSC_VERTEX_ISOLATION_CORE_MACROS_SVH
`define SPARSE_CSC_VERTEX_ISOLATION_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define SCVI_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define SCVI_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[rtl/core/scvi_pkg.sv]
// Shared types and codes for the sparse CSC vertex isolation core.
// No dependencies.
package scvi_pkg;

  typedef struct packed {
    logic [3:0]  func;
    logic [13:0] index;
    logic [13:0] value;
  } scvi_cmd_t;

  typedef struct packed {
    logic [13:0] read_value;
    logic [1:0]  status;
  } scvi_rsp_t;

  localparam logic [3:0] FN_LOAD_START  = 4'd0;
  localparam logic [3:0] FN_LOAD_ROW    = 4'd1;
  localparam logic [3:0] FN_MARK        = 4'd2;
  localparam logic [3:0] FN_COMPUTE     = 4'd3;
  localparam logic [3:0] FN_READ_PERM   = 4'd4;
  localparam logic [3:0] FN_READ_INVP   = 4'd5;
  localparam logic [3:0] FN_READ_START  = 4'd6;
  localparam logic [3:0] FN_READ_ROW    = 4'd7;
  localparam logic [3:0] FN_CLEAR_MARKS = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PARAM = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_WAIT,
    S_READ_WAIT,
    S_CNT_RD,
    S_CNT_WAIT,
    S_PERM_RD,
    S_PERM_WAIT,
    S_COL_RD,
    S_COL_WAIT,
    S_ROW_RD,
    S_ROW_WAIT,
    S_TGT_WAIT,
    S_DONE
  } state_t;

endpackage

[rtl/core/sparse_csc_vertex_isolation_core.sv]
// Sparse CSC vertex isolation core: loads a CSC graph and isolation marks, builds
// the kept-first permutation and the kept subgraph. Depends on scvi_pkg and the macros header.
// Loads and bad commands go straight to S_DONE, marks and reads via a wait state; one in flight.
// Clear marks: one flag entry per cycle through the flag memory.
// Reset: sync; a sweep in S_CLEAR clears the flag memory, cmd_stall high meanwhile.
`include "sparse_csc_vertex_isolation_core_macros.svh"

module sparse_csc_vertex_isolation_core #(
  parameter int MAX_COLUMNS  = 1024,
  parameter int MAX_NONZEROS = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  scvi_pkg::scvi_cmd_t   cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output scvi_pkg::scvi_rsp_t   rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [10:0]           cfg_data
);
  import scvi_pkg::*;

  localparam int VW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNTW = $clog2(MAX_COLUMNS + 1);
  localparam int NZW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int KW   = VW + NZW + 1;

  // memories
  logic            flag_mem [MAX_COLUMNS];
  logic [13:0]     cs_mem   [MAX_COLUMNS + 1];
  logic [10:0]     ri_mem   [MAX_NONZEROS];
  logic [VW-1:0]   perm_mem [MAX_COLUMNS];
  logic [VW-1:0]   invp_mem [MAX_COLUMNS];
  logic [13:0]     ns_mem   [MAX_COLUMNS + 1];
  logic [10:0]     nr_mem   [MAX_NONZEROS];

  logic            flag_we, flag_wd, flag_rd;
  logic [VW-1:0]   flag_wa, flag_ra;
  logic            cs_we;
  logic [CNTW-1:0] cs_wa, cs_ra;
  logic [13:0]     cs_rd;
  logic            ri_we;
  logic [NZW-1:0]  ri_wa, ri_ra;
  logic [10:0]     ri_rd;
  logic            pi_we;
  logic [VW-1:0]   perm_wa, perm_wd, perm_ra, perm_rd;
  logic [VW-1:0]   invp_wa, invp_wd, invp_ra, invp_rd;
  logic            ns_we;
  logic [CNTW-1:0] ns_wa, ns_ra;
  logic [13:0]     ns_wd, ns_rd;
  logic            nr_we;
  logic [NZW-1:0]  nr_wa, nr_ra;
  logic [10:0]     nr_wd, nr_rd;

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    flag_rd <= flag_mem[flag_ra];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_wa] <= cmd.value;
    cs_rd <= cs_mem[cs_ra];
  end

  always_ff @(posedge clk) begin
    if (ri_we) ri_mem[ri_wa] <= cmd.value[10:0];
    ri_rd <= ri_mem[ri_ra];
  end

  always_ff @(posedge clk) begin
    if (pi_we) perm_mem[perm_wa] <= perm_wd;
    perm_rd <= perm_mem[perm_ra];
  end

  always_ff @(posedge clk) begin
    if (pi_we) invp_mem[invp_wa] <= invp_wd;
    invp_rd <= invp_mem[invp_ra];
  end

  always_ff @(posedge clk) begin
    if (ns_we) ns_mem[ns_wa] <= ns_wd;
    ns_rd <= ns_mem[ns_ra];
  end

  always_ff @(posedge clk) begin
    if (nr_we) nr_mem[nr_wa] <= nr_wd;
    nr_rd <= nr_mem[nr_ra];
  end

  // control and working registers
  state_t          state, state_next;
  scvi_cmd_t       cmd_q, cmd_q_next;
  logic [10:0]     num_columns;
  logic [13:0]     base, base_next;
  logic [CNTW-1:0] iso_cnt, iso_cnt_next;
  logic [CNTW-1:0] i, i_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [CNTW-1:0] iso_seen, iso_seen_next;
  logic [CNTW-1:0] newn, newn_next;
  logic [CNTW-1:0] kp, kp_next;
  logic [13:0]     prev_start, prev_start_next;
  logic [13:0]     j, j_next;
  logic [13:0]     hi, hi_next;
  logic [KW-1:0]   k, k_next;
  logic [13:0]     res_val, res_val_next;
  logic [1:0]      res_st, res_st_next;
  logic            clr_reply, clr_reply_next;
  logic            rsp_load;

  logic [CNTW-1:0] n_w;
  logic [CNTW-1:0] pos;
  logic [13:0]     mark_v, lo_off, hi_off, row_v;
  logic            row_ok, adv_row, end_col, adv_col;

  function automatic logic [13:0] offset_of(input logic [13:0] s, input logic [13:0] b);
    return (s >= b) ? (s - b) : 14'd0;
  endfunction

  assign n_w       = CNTW'(num_columns);
  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    base_next       = base;
    iso_cnt_next    = iso_cnt;
    i_next          = i;
    cnt_next        = cnt;
    iso_seen_next   = iso_seen;
    newn_next       = newn;
    kp_next         = kp;
    prev_start_next = prev_start;
    j_next          = j;
    hi_next         = hi;
    k_next          = k;
    res_val_next    = res_val;
    res_st_next     = res_st;
    clr_reply_next  = clr_reply;

    flag_we = 1'b0; flag_wa = '0; flag_wd = 1'b0; flag_ra = '0;
    cs_we   = 1'b0; cs_wa   = '0; cs_ra   = '0;
    ri_we   = 1'b0; ri_wa   = '0; ri_ra   = '0;
    pi_we   = 1'b0; perm_wa = '0; perm_wd = '0; perm_ra = '0;
    invp_wa = '0;   invp_wd = '0; invp_ra = '0;
    ns_we   = 1'b0; ns_wa   = '0; ns_wd   = '0; ns_ra   = '0;
    nr_we   = 1'b0; nr_wa   = '0; nr_wd   = '0; nr_ra   = '0;

    adv_row = 1'b0;
    end_col = 1'b0;
    adv_col = 1'b0;
    pos     = '0;
    mark_v  = '0;
    lo_off  = offset_of(prev_start, base);
    hi_off  = offset_of(cs_rd, base);
    if (32'(hi_off) > MAX_NONZEROS) hi_off = 14'(MAX_NONZEROS);
    row_v   = {3'b000, ri_rd} - base;
    row_ok  = ({3'b000, ri_rd} >= base) && (32'(row_v) < 32'(num_columns));

    case (state)
      S_CLEAR: begin
        flag_we      = 1'b1;
        flag_wa      = VW'(i);
        i_next       = i + 1'b1;
        iso_cnt_next = '0;
        if (i == CNTW'(MAX_COLUMNS - 1)) begin
          i_next       = '0;
          res_val_next = '0;
          res_st_next  = ST_OK;
          state_next   = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_q_next   = cmd;
          res_val_next = '0;
          res_st_next  = ST_OK;
          state_next   = S_DONE;
          case (cmd.func)
            FN_LOAD_START: begin
              if (32'(cmd.index) <= MAX_COLUMNS) begin
                cs_we = 1'b1;
                cs_wa = CNTW'(cmd.index);
                if (cmd.index == 14'd0) base_next = cmd.value;
              end else begin
                res_st_next = ST_RANGE;
              end
            end
            FN_LOAD_ROW: begin
              if (32'(cmd.index) < MAX_NONZEROS) begin
                ri_we = 1'b1;
                ri_wa = NZW'(cmd.index);
              end else begin
                res_st_next = ST_RANGE;
              end
            end
            FN_MARK: begin
              mark_v = cmd.value - base;
              if (cmd.value < base || 32'(mark_v) >= 32'(num_columns) ||
                  32'(num_columns) > MAX_COLUMNS) begin
                res_st_next = ST_RANGE;
              end else begin
                flag_ra    = VW'(mark_v);
                state_next = S_MARK_WAIT;
              end
            end
            FN_COMPUTE: begin
              if (num_columns == 11'd0 || 32'(num_columns) > MAX_COLUMNS ||
                  32'(iso_cnt) > 32'(num_columns)) begin
                res_st_next = ST_BAD_PARAM;
              end else begin
                i_next     = '0;
                cnt_next   = '0;
                state_next = S_CNT_RD;
              end
            end
            FN_READ_PERM, FN_READ_INVP: begin
              if (32'(cmd.index) < MAX_COLUMNS) begin
                perm_ra    = VW'(cmd.index);
                invp_ra    = VW'(cmd.index);
                state_next = S_READ_WAIT;
              end else begin
                res_st_next = ST_RANGE;
              end
            end
            FN_READ_START: begin
              if (32'(cmd.index) <= MAX_COLUMNS) begin
                ns_ra      = CNTW'(cmd.index);
                state_next = S_READ_WAIT;
              end else begin
                res_st_next = ST_RANGE;
              end
            end
            FN_READ_ROW: begin
              if (32'(cmd.index) < MAX_NONZEROS) begin
                nr_ra      = NZW'(cmd.index);
                state_next = S_READ_WAIT;
              end else begin
                res_st_next = ST_RANGE;
              end
            end
            FN_CLEAR_MARKS: begin
              i_next         = '0;
              clr_reply_next = 1'b1;
              state_next     = S_CLEAR;
            end
            default: begin
              res_st_next = ST_BAD_PARAM;
            end
          endcase
        end
      end
      S_MARK_WAIT: begin
        mark_v = cmd_q.value - base;
        if (!flag_rd) begin
          flag_we      = 1'b1;
          flag_wa      = VW'(mark_v);
          flag_wd      = 1'b1;
          iso_cnt_next = iso_cnt + 1'b1;
        end
        state_next = S_DONE;
      end
      S_READ_WAIT: begin
        case (cmd_q.func)
          FN_READ_PERM:  res_val_next = 14'(perm_rd);
          FN_READ_INVP:  res_val_next = 14'(invp_rd);
          FN_READ_START: res_val_next = ns_rd;
          FN_READ_ROW:   res_val_next = {3'b000, nr_rd};
          default:       res_val_next = '0;
        endcase
        state_next = S_DONE;
      end
      S_CNT_RD: begin
        flag_ra    = VW'(i);
        state_next = S_CNT_WAIT;
      end
      S_CNT_WAIT: begin
        cnt_next   = cnt + CNTW'(flag_rd);
        i_next     = i + 1'b1;
        state_next = S_CNT_RD;
        if (i + 1'b1 == n_w) begin
          newn_next     = n_w - cnt - CNTW'(flag_rd);
          i_next        = '0;
          cnt_next      = '0;
          iso_seen_next = '0;
          state_next    = S_PERM_RD;
        end
      end
      S_PERM_RD: begin
        flag_ra    = VW'(i);
        state_next = S_PERM_WAIT;
      end
      S_PERM_WAIT: begin
        pos     = flag_rd ? (newn + iso_seen) : cnt;
        pi_we   = 1'b1;
        invp_wa = VW'(pos);
        invp_wd = VW'(i);
        perm_wa = VW'(i);
        perm_wd = VW'(pos);
        if (flag_rd) iso_seen_next = iso_seen + 1'b1;
        else cnt_next = cnt + 1'b1;
        i_next     = i + 1'b1;
        state_next = S_PERM_RD;
        if (i + 1'b1 == n_w) begin
          i_next          = '0;
          kp_next         = '0;
          k_next          = '0;
          prev_start_next = base;
          ns_we           = 1'b1;
          ns_wa           = '0;
          ns_wd           = base;
          state_next      = S_COL_RD;
        end
      end
      S_COL_RD: begin
        flag_ra    = VW'(i);
        cs_ra      = i + 1'b1;
        state_next = S_COL_WAIT;
      end
      S_COL_WAIT: begin
        prev_start_next = cs_rd;
        if (flag_rd) begin
          adv_col = 1'b1;
        end else if (lo_off >= hi_off) begin
          end_col = 1'b1;
          adv_col = 1'b1;
        end else begin
          j_next     = lo_off;
          hi_next    = hi_off;
          state_next = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        ri_ra      = NZW'(j);
        state_next = S_ROW_WAIT;
      end
      S_ROW_WAIT: begin
        if (row_ok) begin
          perm_ra    = VW'(row_v);
          state_next = S_TGT_WAIT;
        end else begin
          adv_row = 1'b1;
        end
      end
      S_TGT_WAIT: begin
        if (32'(perm_rd) < 32'(newn)) begin
          if (k < KW'(MAX_NONZEROS)) begin
            nr_we = 1'b1;
            nr_wa = NZW'(k);
            nr_wd = 11'(perm_rd) + base[10:0];
          end
          k_next = k + 1'b1;
        end
        adv_row = 1'b1;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (adv_row) begin
      j_next = j + 1'b1;
      if (j + 1'b1 == hi) begin
        end_col = 1'b1;
        adv_col = 1'b1;
      end else begin
        state_next = S_ROW_RD;
      end
    end
    if (end_col) begin
      ns_we   = 1'b1;
      ns_wa   = kp + 1'b1;
      ns_wd   = 14'(k_next) + base;
      kp_next = kp + 1'b1;
    end
    if (adv_col) begin
      i_next     = i + 1'b1;
      state_next = S_COL_RD;
      if (i + 1'b1 == n_w) begin
        res_val_next = 14'(newn);
        res_st_next  = ST_OK;
        state_next   = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      i           <= '0;
      clr_reply   <= 1'b0;
      iso_cnt     <= '0;
      num_columns <= 11'd1;
      rsp_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      i         <= i_next;
      clr_reply <= (state_next == S_CLEAR) ? clr_reply_next : 1'b0;
      iso_cnt   <= iso_cnt_next;
      if (cfg_valid && cfg_ready) num_columns <= cfg_data;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    base       <= base_next;
    cnt        <= cnt_next;
    iso_seen   <= iso_seen_next;
    newn       <= newn_next;
    kp         <= kp_next;
    prev_start <= prev_start_next;
    j          <= j_next;
    hi         <= hi_next;
    k          <= k_next;
    res_val    <= res_val_next;
    res_st     <= res_st_next;
    if (rsp_load) begin
      rsp.read_value <= res_val;
      rsp.status     <= res_st;
    end
  end

  `SCVI_ASSERT_NEXT(a_accept_starts, cmd_valid && !cmd_stall, state != S_IDLE, "accepted beat did not start")
  `SCVI_ASSERT_NEXT(a_done_delivers, rsp_load, rsp_valid && (state == S_IDLE), "result beat not registered")
  `SCVI_ASSERT_NOW(a_kept_bound, (state != S_COL_RD) || (kp <= newn), "kept column index overran")
  `SCVI_ASSERT_NOW(a_mark_bound, 32'(iso_cnt) <= MAX_COLUMNS, "mark count overran")

endmodule
